/* sv/cosine_warmup_lr_schedule_assert.svh */
// assertion helpers for the schedule module
// both expect clk and rst_n in scope
`ifndef COSINE_WARMUP_LR_SCHEDULE_ASSERT_SVH
`define COSINE_WARMUP_LR_SCHEDULE_ASSERT_SVH

// same-cycle implication
`define CWLR_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CWLR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cwlr_pkg.sv */
package cwlr_pkg;

    localparam int DEF_STEP_BITS      = 32;
    localparam int DEF_RATE_FRAC_BITS = 24;
    localparam int DEF_COS_TABLE_BITS = 10;

    localparam int CFG_INDEX_W = 3;

    // floor factor and half-cosine entries are Q1.16, one integer bit and 16 fraction bits
    localparam int              FACTOR_W    = 17;
    localparam int              FACTOR_FRAC = 16;
    localparam logic [16:0]     FACTOR_ONE  = 17'h10000;

    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam logic [63:0] PI_Q30       = 64'd3373259426;
    localparam int          TAYLOR_TERMS = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_RATE    = 3'd0,
        REG_MODE         = 3'd1,
        REG_WARMUP_LEN   = 3'd2,
        REG_TOTAL_LEN    = 3'd3,
        REG_FLOOR_FACTOR = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_CONST  = 2'd0,
        PH_WARMUP = 2'd1,
        PH_DECAY  = 2'd2,
        PH_FLOOR  = 2'd3
    } phase_t;

    // half-cosine entry 0.5*(1+cos(pi*idx/2^bits)) in Q1.16, taylor series in Q2.30
    function automatic logic [16:0] cos_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0] n;
        logic [63:0] i;
        logic [63:0] j;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] uc;
        logic [63:0] h;
        longint      c;
        logic        low_half;
        int          k;
        n        = 64'd1 << bits;
        i        = 64'(idx);
        low_half = ((i << 1) <= n);
        j        = low_half ? i : n - i;
        x        = (PI_Q30 * j) >> bits;
        x2       = (x * x) >> 30;
        term     = ONE_Q30;
        c        = longint'(ONE_Q30);
        for (k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k[0])
            begin
                c = c - longint'(term);
            end
            else
            begin
                c = c + longint'(term);
            end
        end
        if (c < 0)
        begin
            c = 0;
        end
        uc = 64'(c);
        if (uc > ONE_Q30)
        begin
            uc = ONE_Q30;
        end
        h = low_half ? (ONE_Q30 + uc) >> 15 : (ONE_Q30 - uc) >> 15;
        return h[16:0];
    endfunction

endpackage

/* sv/cwlr_div.sv */
module cwlr_div #(
    parameter int DEN_W  = 32,
    parameter int Q_W    = 24,
    parameter int SIDE_W = 26
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic              item_valid,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [Q_W-1:0]    quo_init,
    input  logic [DEN_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side,
    output logic              done_valid,
    output logic [Q_W-1:0]    quotient,
    output logic [SIDE_W-1:0] done_side
);

    // one quotient bit per stage; rem_init must be below the divisor
    // for the quotient to be exact, which holds for every divide we use
    logic              valid_reg [Q_W];
    logic [DEN_W-1:0]  rem_reg   [Q_W];
    logic [Q_W-1:0]    low_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    logic              valid_in  [Q_W];
    logic [DEN_W-1:0]  rem_in    [Q_W];
    logic [Q_W-1:0]    low_in    [Q_W];
    logic [DEN_W-1:0]  den_in    [Q_W];
    logic [SIDE_W-1:0] side_in   [Q_W];

    logic [DEN_W-1:0]  rem_next  [Q_W];
    logic [Q_W-1:0]    low_next  [Q_W];

    always_comb
    begin
        valid_in[0] = item_valid;
        rem_in[0]   = rem_init;
        low_in[0]   = quo_init;
        den_in[0]   = divisor;
        side_in[0]  = side;
        for (int s = 1; s < Q_W; s++)
        begin
            valid_in[s] = valid_reg[s-1];
            rem_in[s]   = rem_reg[s-1];
            low_in[s]   = low_reg[s-1];
            den_in[s]   = den_reg[s-1];
            side_in[s]  = side_reg[s-1];
        end
    end

    always_comb
    begin
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        for (int s = 0; s < Q_W; s++)
        begin
            trial       = {rem_in[s], low_in[s][Q_W-1]};
            diff        = trial - {1'b0, den_in[s]};
            ge          = (trial >= {1'b0, den_in[s]});
            rem_next[s] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next[s] = {low_in[s][Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (enable)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                valid_reg[s] <= valid_in[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                low_reg[s]  <= low_next[s];
                den_reg[s]  <= den_in[s];
                side_reg[s] <= side_in[s];
            end
        end
    end

    assign done_valid = valid_reg[Q_W-1];
    assign quotient   = low_reg[Q_W-1];
    assign done_side  = side_reg[Q_W-1];

endmodule

/* sv/cosine_warmup_lr_schedule.sv */
// Learning-rate schedule, cosine annealing with linear warmup. Each step word gives one
// result word (Q0.24 rate and phase), and a new step can be taken every cycle while
// step_stall is low. The shared restoring divider resolves one quotient bit per stage
// for both the warmup ratio and the cosine table index; two front stages form the products
// and operands, three back stages read the half-cosine ROM, multiply and add the floor. A
// one-word skid buffer lets the pipeline drain one result into it when the output stalls.
// The configuration port is always ready; registers must only be written while no step is
// in flight.
module cosine_warmup_lr_schedule #(
    parameter int  STEP_BITS      = cwlr_pkg::DEF_STEP_BITS,
    parameter int  RATE_FRAC_BITS = cwlr_pkg::DEF_RATE_FRAC_BITS,
    parameter int  COS_TABLE_BITS = cwlr_pkg::DEF_COS_TABLE_BITS,
    localparam int CFG_W_A        = (STEP_BITS > RATE_FRAC_BITS) ? STEP_BITS : RATE_FRAC_BITS,
    localparam int CFG_W          = (CFG_W_A > cwlr_pkg::FACTOR_W) ? CFG_W_A : cwlr_pkg::FACTOR_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cwlr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          step_valid,
    output logic                          step_stall,
    input  logic [STEP_BITS-1:0]          step_index,
    output logic                          rate_valid,
    input  logic                          rate_stall,
    output logic [RATE_FRAC_BITS-1:0]     learning_rate,
    output logic [1:0]                    phase
);

    `include "cosine_warmup_lr_schedule_assert.svh"

    localparam int RW     = RATE_FRAC_BITS;
    localparam int FW     = cwlr_pkg::FACTOR_W;
    localparam int FFRAC  = cwlr_pkg::FACTOR_FRAC;
    localparam int QW     = (RATE_FRAC_BITS > COS_TABLE_BITS) ? RATE_FRAC_BITS : COS_TABLE_BITS;
    localparam int NUM_W  = STEP_BITS + QW;
    localparam int PROD_W = RATE_FRAC_BITS + STEP_BITS;
    localparam int HALF   = (STEP_BITS + 1) / 2;
    localparam int HI_W   = STEP_BITS - HALF;
    localparam int PLO_W  = RATE_FRAC_BITS + HALF;
    localparam int PHI_W  = RATE_FRAC_BITS + HI_W;
    localparam int MUL_W  = RATE_FRAC_BITS + cwlr_pkg::FACTOR_W;
    localparam int SIDE_W = RATE_FRAC_BITS + 2;
    localparam int ROM_N  = 1 << COS_TABLE_BITS;

    // configuration registers
    logic [RW-1:0]        base_rate_reg;
    logic                 schedule_mode_reg;
    logic [STEP_BITS-1:0] warmup_len_reg;
    logic [STEP_BITS-1:0] total_len_reg;
    logic [FW-1:0]        floor_factor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_rate_reg     <= '0;
            schedule_mode_reg <= 1'b0;
            warmup_len_reg    <= '0;
            total_len_reg     <= '0;
            floor_factor_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cwlr_pkg::REG_BASE_RATE:    base_rate_reg     <= cfg_data[RW-1:0];
                cwlr_pkg::REG_MODE:         schedule_mode_reg <= cfg_data[0];
                cwlr_pkg::REG_WARMUP_LEN:   warmup_len_reg    <= cfg_data[STEP_BITS-1:0];
                cwlr_pkg::REG_TOTAL_LEN:    total_len_reg     <= cfg_data[STEP_BITS-1:0];
                cwlr_pkg::REG_FLOOR_FACTOR: floor_factor_reg  <= cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the skid word is occupied
    logic skid_valid_reg;
    logic adv;

    assign adv        = !skid_valid_reg;
    assign step_stall = skid_valid_reg;

    // stage 1: compares, warmup product halves, floor product
    logic                 s1_valid_reg;
    logic                 s1_warm_reg;
    logic [STEP_BITS-1:0] s1_d_reg;
    logic [STEP_BITS-1:0] s1_hor_reg;
    logic [PLO_W-1:0]     s1_plo_reg;
    logic [PHI_W-1:0]     s1_phi_reg;
    logic [MUL_W-1:0]     s1_fprod_reg;

    logic                 s1_warm_next;
    logic [STEP_BITS-1:0] s1_d_next;
    logic [STEP_BITS-1:0] s1_hor_next;
    logic [PLO_W-1:0]     s1_plo_next;
    logic [PHI_W-1:0]     s1_phi_next;
    logic [MUL_W-1:0]     s1_fprod_next;
    logic [FW-1:0]        factor_sat;

    always_comb
    begin
        factor_sat    = (floor_factor_reg > cwlr_pkg::FACTOR_ONE) ? cwlr_pkg::FACTOR_ONE
                                                                 : floor_factor_reg;
        s1_warm_next  = (warmup_len_reg != '0) && (step_index <= warmup_len_reg);
        s1_d_next     = step_index - warmup_len_reg;
        s1_hor_next   = (total_len_reg > warmup_len_reg) ? total_len_reg - warmup_len_reg : '0;
        s1_plo_next   = PLO_W'(base_rate_reg) * PLO_W'(step_index[HALF-1:0]);
        s1_phi_next   = PHI_W'(base_rate_reg) * PHI_W'(step_index[STEP_BITS-1:HALF]);
        s1_fprod_next = MUL_W'(base_rate_reg) * MUL_W'(factor_sat);
    end

    // stage 2: phase decision and divider operands
    logic                 s2_valid_reg;
    logic [NUM_W-1:0]     s2_num_reg;
    logic [STEP_BITS-1:0] s2_den_reg;
    cwlr_pkg::phase_t     s2_phase_reg;
    logic [RW-1:0]        s2_flr_reg;

    logic [PROD_W-1:0]    s2_prod;
    logic [NUM_W-1:0]     s2_num_next;
    logic [STEP_BITS-1:0] s2_den_next;
    cwlr_pkg::phase_t     s2_phase_next;
    logic                 s2_at_floor;

    always_comb
    begin
        s2_prod     = PROD_W'(s1_plo_reg) + (PROD_W'(s1_phi_reg) << HALF);
        s2_at_floor = (s1_hor_reg == '0) || (s1_d_reg >= s1_hor_reg);
        if (!schedule_mode_reg)
        begin
            s2_phase_next = cwlr_pkg::PH_CONST;
        end
        else if (s1_warm_reg)
        begin
            s2_phase_next = cwlr_pkg::PH_WARMUP;
        end
        else if (s2_at_floor)
        begin
            s2_phase_next = cwlr_pkg::PH_FLOOR;
        end
        else
        begin
            s2_phase_next = cwlr_pkg::PH_DECAY;
        end
        // warmup: base*step/warmup, decay: d*2^T/horizon
        s2_num_next = s1_warm_reg ? NUM_W'(s2_prod) : (NUM_W'(s1_d_reg) << COS_TABLE_BITS);
        s2_den_next = s1_warm_reg ? warmup_len_reg : s1_hor_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= step_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_warm_reg  <= s1_warm_next;
            s1_d_reg     <= s1_d_next;
            s1_hor_reg   <= s1_hor_next;
            s1_plo_reg   <= s1_plo_next;
            s1_phi_reg   <= s1_phi_next;
            s1_fprod_reg <= s1_fprod_next;
            s2_num_reg   <= s2_num_next;
            s2_den_reg   <= s2_den_next;
            s2_phase_reg <= s2_phase_next;
            s2_flr_reg   <= s1_fprod_reg[FFRAC +: RW];
        end
    end

    // shared divider
    logic              dv_valid;
    logic [QW-1:0]     dv_quot;
    logic [SIDE_W-1:0] dv_side;
    cwlr_pkg::phase_t  dv_phase;
    logic [RW-1:0]     dv_flr;

    cwlr_div #(
        .DEN_W  (STEP_BITS),
        .Q_W    (QW),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (adv),
        .item_valid (s2_valid_reg),
        .rem_init   (s2_num_reg[NUM_W-1:QW]),
        .quo_init   (s2_num_reg[QW-1:0]),
        .divisor    (s2_den_reg),
        .side       ({s2_phase_reg, s2_flr_reg}),
        .done_valid (dv_valid),
        .quotient   (dv_quot),
        .done_side  (dv_side)
    );

    assign dv_phase = cwlr_pkg::phase_t'(dv_side[SIDE_W-1 -: 2]);
    assign dv_flr   = dv_side[RW-1:0];

    // half-cosine rom, constant contents
    logic [FW-1:0] cos_rom [ROM_N];

    for (genvar g = 0; g < ROM_N; g++)
    begin : g_rom
        assign cos_rom[g] = cwlr_pkg::cos_entry(g, COS_TABLE_BITS);
    end

    // back stages: rom read, multiply, add floor
    logic             e1_valid_reg;
    logic [FW-1:0]    e1_h_reg;
    logic [RW-1:0]    e1_diff_reg;
    logic [RW-1:0]    e1_quot_reg;
    cwlr_pkg::phase_t e1_phase_reg;
    logic [RW-1:0]    e1_flr_reg;

    logic             e2_valid_reg;
    logic [MUL_W-1:0] e2_hprod_reg;
    logic [RW-1:0]    e2_quot_reg;
    cwlr_pkg::phase_t e2_phase_reg;
    logic [RW-1:0]    e2_flr_reg;

    logic             last_valid_reg;
    logic [RW-1:0]    last_rate_reg;
    cwlr_pkg::phase_t last_phase_reg;
    logic [RW-1:0]    last_rate_next;

    always_comb
    begin
        case (e2_phase_reg)
            cwlr_pkg::PH_CONST:  last_rate_next = base_rate_reg;
            cwlr_pkg::PH_WARMUP: last_rate_next = e2_quot_reg;
            cwlr_pkg::PH_DECAY:  last_rate_next = e2_flr_reg + e2_hprod_reg[FFRAC +: RW];
            cwlr_pkg::PH_FLOOR:  last_rate_next = e2_flr_reg;
            default:             last_rate_next = e2_flr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg   <= 1'b0;
            e2_valid_reg   <= 1'b0;
            last_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e1_valid_reg   <= dv_valid;
            e2_valid_reg   <= e1_valid_reg;
            last_valid_reg <= e2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_h_reg       <= cos_rom[dv_quot[COS_TABLE_BITS-1:0]];
            e1_diff_reg    <= base_rate_reg - dv_flr;
            e1_quot_reg    <= dv_quot[RW-1:0];
            e1_phase_reg   <= dv_phase;
            e1_flr_reg     <= dv_flr;
            e2_hprod_reg   <= MUL_W'(e1_diff_reg) * MUL_W'(e1_h_reg);
            e2_quot_reg    <= e1_quot_reg;
            e2_phase_reg   <= e1_phase_reg;
            e2_flr_reg     <= e1_flr_reg;
            last_rate_reg  <= last_rate_next;
            last_phase_reg <= e2_phase_reg;
        end
    end

    // skid word holds a result that met a stall so the pipeline can still step once
    logic             skid_valid_next;
    logic [RW-1:0]    skid_rate_reg;
    cwlr_pkg::phase_t skid_phase_reg;

    always_comb
    begin
        if (skid_valid_reg)
        begin
            skid_valid_next = rate_stall;
        end
        else
        begin
            skid_valid_next = last_valid_reg && rate_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && last_valid_reg && rate_stall)
        begin
            skid_rate_reg  <= last_rate_reg;
            skid_phase_reg <= last_phase_reg;
        end
    end

    assign rate_valid    = skid_valid_reg || last_valid_reg;
    assign learning_rate = skid_valid_reg ? skid_rate_reg : last_rate_reg;
    assign phase         = skid_valid_reg ? skid_phase_reg : last_phase_reg;

    `CWLR_ASSERT_IMPL(a_decay_index_in_range, dv_valid && dv_phase == cwlr_pkg::PH_DECAY, (dv_quot >> COS_TABLE_BITS) == '0, "decay quotient exceeds table index range")
    `CWLR_ASSERT_NEXT(a_skid_freezes_last, skid_valid_reg && last_valid_reg, $stable(last_rate_reg) && last_valid_reg, "last stage moved while skid word was held")
    `CWLR_ASSERT_IMPL(a_skid_fill_cause, $rose(skid_valid_reg), $past(last_valid_reg && rate_stall), "skid word filled without a stalled result")

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_W       = cwlr_pkg::DEF_STEP_BITS;
    localparam int RATE_W       = cwlr_pkg::DEF_RATE_FRAC_BITS;
    localparam int ROM_BITS     = cwlr_pkg::DEF_COS_TABLE_BITS;
    localparam int ROM_N        = 1 << ROM_BITS;
    localparam int FAC_W        = cwlr_pkg::FACTOR_W;
    localparam int IDX_W        = cwlr_pkg::CFG_INDEX_W;
    localparam int CFG_W_A      = (STEP_W > RATE_W) ? STEP_W : RATE_W;
    localparam int CFG_DATA_W   = (CFG_W_A > FAC_W) ? CFG_W_A : FAC_W;
    localparam int PIPE_LATENCY = 29;
    localparam int SETTLE_WAIT  = PIPE_LATENCY + 8;
    localparam int STUCK_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 75;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        cwlr_pkg::phase_t  ph;
    } rate_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   step_valid = 1'b0;
    logic                   step_stall;
    logic [STEP_W-1:0]      step_index = '0;
    logic                   rate_valid;
    logic                   rate_stall = 1'b0;
    logic [RATE_W-1:0]      learning_rate;
    logic [1:0]             phase;

    // schedule registers as the block should hold them
    logic [RATE_W-1:0]   cfg_base = '0;
    logic                cfg_mode = 1'b0;
    logic [STEP_W-1:0]   cfg_warmup = '0;
    logic [STEP_W-1:0]   cfg_total = '0;
    logic [FAC_W-1:0]    cfg_factor = '0;

    logic [FAC_W-1:0]    half_cos_rom [ROM_N];
    rate_word_t          expected_rates [$];
    rate_word_t          oldest_rate;
    int                  err_count = 0;
    int                  stuck_cycles = 0;
    bit                  tx_idle_en = 1'b1;
    bit                  rx_idle_en = 1'b1;
    bit                  hold_request = 1'b0;

    cosine_warmup_lr_schedule i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .step_valid    (step_valid),
        .step_stall    (step_stall),
        .step_index    (step_index),
        .rate_valid    (rate_valid),
        .rate_stall    (rate_stall),
        .learning_rate (learning_rate),
        .phase         (phase)
    );

    always #5 clk = ~clk;

    // 0.5*(1+cos(pi*i/N)) in Q1.16 from a truncated taylor series in Q2.30
    function automatic logic [FAC_W-1:0] half_cos_q16(input int unsigned i);
        logic [63:0] j;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] uc;
        logic [63:0] h;
        longint      acc;
        bit          low_half;
        low_half = (2 * i <= ROM_N);
        j        = low_half ? 64'(i) : 64'(ROM_N - i);
        x        = (cwlr_pkg::PI_Q30 * j) / 64'(ROM_N);
        x2       = (x * x) >> 30;
        term     = cwlr_pkg::ONE_Q30;
        acc      = longint'(cwlr_pkg::ONE_Q30);
        for (int k = 1; k <= cwlr_pkg::TAYLOR_TERMS; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        uc = 64'(acc);
        if (uc > cwlr_pkg::ONE_Q30)
        begin
            uc = cwlr_pkg::ONE_Q30;
        end
        h = low_half ? (cwlr_pkg::ONE_Q30 + uc) >> 15 : (cwlr_pkg::ONE_Q30 - uc) >> 15;
        return h[FAC_W-1:0];
    endfunction

    function automatic rate_word_t predict_rate(input logic [STEP_W-1:0] s);
        logic [63:0] base;
        logic [63:0] fac;
        logic [63:0] flr;
        logic [63:0] hor;
        logic [63:0] d;
        logic [63:0] idx;
        logic [63:0] r;
        rate_word_t  w;
        base = 64'(cfg_base);
        if (cfg_mode != 1'b1)
        begin
            r    = base;
            w.ph = cwlr_pkg::PH_CONST;
        end
        else if (cfg_warmup != '0 && s <= cfg_warmup)
        begin
            r    = base * 64'(s) / 64'(cfg_warmup);
            w.ph = cwlr_pkg::PH_WARMUP;
        end
        else
        begin
            fac = (cfg_factor > cwlr_pkg::FACTOR_ONE) ? 64'(cwlr_pkg::FACTOR_ONE)
                                                      : 64'(cfg_factor);
            flr = (base * fac) >> cwlr_pkg::FACTOR_FRAC;
            hor = (cfg_total > cfg_warmup) ? 64'(cfg_total) - 64'(cfg_warmup) : 64'd0;
            d   = 64'(s) - 64'(cfg_warmup);
            if (hor == 64'd0 || d >= hor)
            begin
                r    = flr;
                w.ph = cwlr_pkg::PH_FLOOR;
            end
            else
            begin
                idx  = (64'(ROM_N) * d / hor) & 64'(ROM_N - 1);
                r    = flr + (((base - flr) * 64'(half_cos_rom[idx])) >> cwlr_pkg::FACTOR_FRAC);
                w.ph = cwlr_pkg::PH_DECAY;
            end
        end
        w.rate = r[RATE_W-1:0];
        return w;
    endfunction

    // steps weighted toward the decay span, with the boundaries and some noise
    function automatic logic [STEP_W-1:0] pick_step();
        logic [63:0] hor;
        logic [63:0] s;
        hor = (cfg_total > cfg_warmup) ? 64'(cfg_total) - 64'(cfg_warmup) : 64'd0;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                s = 64'($urandom_range(0, cfg_warmup));
            end
            2, 3, 4, 5, 6:
            begin
                if (hor == 64'd0)
                begin
                    s = 64'(cfg_warmup) + 64'($urandom_range(0, 3));
                end
                else
                begin
                    s = 64'(cfg_warmup) + 64'($urandom_range(0, hor[31:0] - 1));
                end
            end
            7:
            begin
                s = ($urandom_range(0, 1) ? 64'(cfg_warmup) : 64'(cfg_total))
                    + 64'($urandom_range(0, 2));
                s = (s == 64'd0) ? 64'd0 : s - 64'd1;
            end
            8:
            begin
                s = 64'(cfg_total) + 64'($urandom_range(0, 1000));
            end
            default:
            begin
                s = 64'($urandom);
            end
        endcase
        if (s > 64'(STEP_MAX))
        begin
            s = 64'(STEP_MAX);
        end
        return s[STEP_W-1:0];
    endfunction

    // leaves cfg_valid high so back-to-back writes keep one assignment per edge
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            cwlr_pkg::REG_BASE_RATE:    cfg_base   = d[RATE_W-1:0];
            cwlr_pkg::REG_MODE:         cfg_mode   = d[0];
            cwlr_pkg::REG_WARMUP_LEN:   cfg_warmup = d[STEP_W-1:0];
            cwlr_pkg::REG_TOTAL_LEN:    cfg_total  = d[STEP_W-1:0];
            cwlr_pkg::REG_FLOOR_FACTOR: cfg_factor = d[FAC_W-1:0];
            default:                    ;
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] base,
                             input logic [CFG_DATA_W-1:0] mode,
                             input logic [CFG_DATA_W-1:0] warmup,
                             input logic [CFG_DATA_W-1:0] total,
                             input logic [CFG_DATA_W-1:0] factor);
        write_reg(cwlr_pkg::REG_BASE_RATE, base);
        write_reg(cwlr_pkg::REG_MODE, mode);
        write_reg(cwlr_pkg::REG_WARMUP_LEN, warmup);
        write_reg(cwlr_pkg::REG_TOTAL_LEN, total);
        write_reg(cwlr_pkg::REG_FLOOR_FACTOR, factor);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_step(input logic [STEP_W-1:0] s);
        step_valid <= 1'b1;
        step_index <= s;
        do
        begin
            @(posedge clk);
        end
        while (step_stall);
        expected_rates.insert(expected_rates.size(), predict_rate(s));
        @(negedge clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            step_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // wait for every word to come back, then for the pipe to empty
    task automatic settle();
        step_valid <= 1'b0;
        while (expected_rates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic test_reset_defaults();
        offer_step('0);
        offer_step(STEP_MAX);
        offer_step($urandom);
        settle();
    endtask

    task automatic test_constant_mode();
        configure(RATE_MAX, 0, 7, 9, 32'h100);
        offer_step('0);
        offer_step(STEP_MAX);
        offer_step(12345);
        settle();
    endtask

    task automatic test_warmup_ramp();
        configure(RATE_MAX, 1, 100, 1000, 32'h4000);
        offer_step(1);
        offer_step(50);
        offer_step(99);
        offer_step(100);
        offer_step(101);
        offer_step(550);
        offer_step(999);
        offer_step(1000);
        offer_step(1001);
        settle();
    endtask

    task automatic test_special_cases();
        // floor factor above one saturates, with no horizon the rate is the floor
        configure(RATE_MAX, 1, 0, 0, 32'h1FFFF);
        offer_step(5);
        settle();
        configure(24'hABCDEF, 1, 10, 4000, 32'h10001);
        offer_step(2000);
        settle();
        // step zero inside warmup
        configure(24'hABCDEF, 1, 10, 20, 32'h8000);
        offer_step('0);
        settle();
        // step zero with warmup off starts the decay
        configure(24'h123456, 1, 0, 1000, 32'h2000);
        offer_step('0);
        offer_step(STEP_MAX);
        settle();
        // total not above warmup leaves no decay span
        configure(24'h654321, 1, 50, 30, 32'h3000);
        offer_step(50);
        offer_step(51);
        settle();
        configure(RATE_MAX, 1, STEP_MAX, STEP_MAX, 32'h10000);
        offer_step(STEP_MAX);
        offer_step(32'h7FFF_FFFF);
        settle();
        // unused register indexes must not disturb the schedule
        for (int k = int'(cwlr_pkg::REG_FLOOR_FACTOR) + 1; k < (1 << IDX_W); k++)
        begin
            write_reg(IDX_W'(k), $urandom);
        end
        cfg_valid <= 1'b0;
        offer_step(STEP_MAX);
        settle();
    endtask

    task automatic test_backpressure();
        configure(RATE_MAX, 1, 64, 2048, 32'h1000);
        tx_idle_en   = 1'b0;
        hold_request = 1'b1;
        repeat (80) offer_step(pick_step());
        tx_idle_en = 1'b1;
        settle();
    endtask

    task automatic test_random_schedules();
        logic [CFG_DATA_W-1:0] base_d;
        logic [CFG_DATA_W-1:0] mode_d;
        logic [CFG_DATA_W-1:0] fac_d;
        logic [63:0]           warmup;
        logic [63:0]           total;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            base_d = $urandom;
            case ($urandom_range(0, 7))
                0:       base_d[RATE_W-1:0] = '0;
                1:       base_d[RATE_W-1:0] = RATE_MAX;
                default: ;
            endcase
            mode_d    = $urandom;
            mode_d[0] = ($urandom_range(0, 5) != 0);
            case ($urandom_range(0, 9))
                0:       warmup = 64'd0;
                1:       warmup = 64'(STEP_MAX);
                2:       warmup = 64'($urandom);
                default: warmup = 64'($urandom_range(1, 300));
            endcase
            case ($urandom_range(0, 9))
                0:       total = 64'd0;
                1:       total = 64'(STEP_MAX);
                2:       total = (warmup == 64'd0) ? 64'd0
                                 : 64'($urandom_range(0, warmup[31:0] - 1));
                3:       total = warmup;
                default: total = warmup + 64'($urandom_range(1, 4000));
            endcase
            if (total > 64'(STEP_MAX))
            begin
                total = 64'(STEP_MAX);
            end
            fac_d = $urandom;
            case ($urandom_range(0, 7))
                0:       fac_d[FAC_W-1:0] = '0;
                1:       fac_d[FAC_W-1:0] = cwlr_pkg::FACTOR_ONE;
                2:       fac_d[FAC_W-1:0] = FAC_W'($urandom_range(32'h10001, 32'h1FFFF));
                default: fac_d[FAC_W-1:0] = FAC_W'($urandom_range(0, 32'hFFFF));
            endcase
            // the closing phases run with no idling at all
            tx_idle_en = (p < PHASE_COUNT - 2) && (p % 3 != 1);
            rx_idle_en = (p < PHASE_COUNT - 2) && (p % 3 != 2);
            configure(base_d, mode_d, warmup[31:0], total[31:0], fac_d);
            repeat (PHASE_ITEMS) offer_step(pick_step());
            settle();
        end
    endtask

    // receiver stalls in bursts, or for one long stretch when asked
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                rate_stall   <= 1'b1;
                hold_request  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                rate_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            else
            begin
                rate_stall <= 1'b0;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rate_valid && !rate_stall)
        begin
            if (expected_rates.size() == 0)
            begin
                $error("result word with nothing expected: learning_rate %h phase %0d",
                       learning_rate, phase);
                err_count++;
            end
            else
            begin
                oldest_rate = expected_rates.pop_front();
                if (learning_rate !== oldest_rate.rate)
                begin
                    $error("learning_rate: expected %h, actual %h", oldest_rate.rate,
                           learning_rate);
                    err_count++;
                end
                if (phase !== oldest_rate.ph)
                begin
                    $error("phase: expected %0d, actual %0d", oldest_rate.ph, phase);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((step_valid && !step_stall) || (rate_valid && !rate_stall)
                || (cfg_valid && cfg_ready))
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < ROM_N; i++)
        begin
            half_cos_rom[i] = half_cos_q16(i);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_constant_mode();
        test_warmup_ramp();
        test_special_cases();
        test_backpressure();
        test_random_schedules();
        settle();
        if (err_count == 0 && expected_rates.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/cwlr_pkg.sv
sv/cwlr_div.sv
sv/cosine_warmup_lr_schedule.sv
bench/testbench.sv
